/* rtl/cfd_pkg.sv */
// ----------------------------------------------------------------------------
// cfd_pkg
// Shared types and constants for the command frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none
package cfd_pkg;

  localparam int unsigned MAX_PAYLOAD  = 16;
  localparam int unsigned BUFFER_DEPTH = 32;

  localparam logic [7:0] HDR_BYTE  = 8'h3C;
  localparam logic [7:0] END_BYTE  = 8'hF3;
  localparam int unsigned MIN_JUDGE = 10;
  localparam int unsigned OVERHEAD  = 11;
  localparam int unsigned HDR_LEN   = 8;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SCAN  = 9'b000000010,
    S_HRD   = 9'b000000100,
    S_HCAP  = 9'b000001000,
    S_LCHK  = 9'b000010000,
    S_TCHK  = 9'b000100000,
    S_EMPTY = 9'b001000000,
    S_PRD   = 9'b010000000,
    S_PWAIT = 9'b100000000
  } cfd_state_t;

  // controller to datapath
  typedef struct packed {
    logic push;
    logic scan_start;
    logic rd_hdr;
    logic cap_hdr;
    logic rd_term;
    logic pay_start;
    logic rd_pay;
    logic load_out;
    logic drop1;
    logic drop_frame;
  } cfd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic fill_ge_min;
    logic hdr_bad;
    logic hdr_last;
    logic len_ok;
    logic complete;
    logic term_ok;
    logic len_zero;
    logic pay_last;
    logic out_free;
  } cfd_stat_t;

endpackage
`default_nettype wire

/* rtl/cfd_if.sv */
// ----------------------------------------------------------------------------
// cfd_in_if / cfd_out_if
// Valid/ready channels for received bytes and deframed results.
// ----------------------------------------------------------------------------
`default_nettype none
interface cfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] command_major;
  logic [7:0] command_minor;
  logic [4:0] payload_length;
  logic [3:0] byte_index;
  logic [7:0] payload_byte;
  logic       has_payload;
  logic       last;
  modport source (output valid, output command_major, output command_minor,
                  output payload_length, output byte_index, output payload_byte,
                  output has_payload, output last, input ready);
  modport sink   (input valid, input command_major, input command_minor,
                  input payload_length, input byte_index, input payload_byte,
                  input has_payload, input last, output ready);
endinterface
`default_nettype wire

/* rtl/cfd_ram.sv */
// ----------------------------------------------------------------------------
// cfd_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module cfd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem_r [Depth];
  logic [Width-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

/* rtl/cfd_ctrl.sv */
// ----------------------------------------------------------------------------
// cfd_ctrl
// Scan sequencer: header walk, length and terminator checks, payload emit.
// ----------------------------------------------------------------------------
`default_nettype none
module cfd_ctrl
  import cfd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire cfd_stat_t stat,
  output cfd_cmd_t       cmd
);
  cfd_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.push  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!stat.fill_ge_min) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_HRD;
        end
      end
      S_HRD: begin
        cmd.rd_hdr = 1'b1;
        state_nxt  = S_HCAP;
      end
      S_HCAP: begin
        if (stat.hdr_bad) begin
          cmd.drop1 = 1'b1;
          state_nxt = S_SCAN;
        end else begin
          cmd.cap_hdr = 1'b1;
          state_nxt   = stat.hdr_last ? S_LCHK : S_HRD;
        end
      end
      S_LCHK: begin
        if (!stat.len_ok) begin
          cmd.drop1 = 1'b1;
          state_nxt = S_SCAN;
        end else if (!stat.complete) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.rd_term = 1'b1;
          state_nxt   = S_TCHK;
        end
      end
      S_TCHK: begin
        if (!stat.term_ok) begin
          cmd.drop1 = 1'b1;
          state_nxt = S_SCAN;
        end else begin
          cmd.pay_start = 1'b1;
          state_nxt     = stat.len_zero ? S_EMPTY : S_PRD;
        end
      end
      S_EMPTY: begin
        if (stat.out_free) begin
          cmd.load_out   = 1'b1;
          cmd.drop_frame = 1'b1;
          state_nxt      = S_SCAN;
        end
      end
      S_PRD: begin
        cmd.rd_pay = 1'b1;
        state_nxt  = S_PWAIT;
      end
      S_PWAIT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          if (stat.pay_last) begin
            cmd.drop_frame = 1'b1;
            state_nxt      = S_SCAN;
          end else begin
            state_nxt = S_PRD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end
endmodule
`default_nettype wire

/* rtl/cfd_dp.sv */
// ----------------------------------------------------------------------------
// cfd_dp
// Ring buffer, header registers, offset arithmetic and result register.
// ----------------------------------------------------------------------------
`default_nettype none
module cfd_dp
  import cfd_pkg::*;
#(
  parameter int unsigned MaxPayload  = MAX_PAYLOAD,
  parameter int unsigned BufferDepth = BUFFER_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [7:0] rx_byte,
  input  wire cfd_cmd_t   cmd,
  output cfd_stat_t       stat,
  input  wire logic       out_ready,
  output logic            out_valid,
  output logic [7:0]      command_major,
  output logic [7:0]      command_minor,
  output logic [4:0]      payload_length,
  output logic [3:0]      byte_index,
  output logic [7:0]      payload_byte,
  output logic            has_payload,
  output logic            last
);
  localparam int unsigned PW = $clog2(BufferDepth);
  localparam int unsigned FW = $clog2(BufferDepth + 1);
  localparam int unsigned OW = $clog2(2 * BufferDepth + MaxPayload + OVERHEAD + 1);
  localparam int unsigned IW = $clog2(MaxPayload + 1);
  localparam logic [OW-1:0] DEPTH_O = OW'(BufferDepth);

  logic [PW-1:0] head_r;
  logic [FW-1:0] fill_r;
  logic [2:0]    hoff_r;
  logic [7:0]    hb_r [HDR_LEN];
  logic [IW-1:0] idx_r;

  logic          ov_r;
  logic [7:0]    o_maj_r, o_min_r, o_byte_r;
  logic [4:0]    o_len_r;
  logic [3:0]    o_idx_r;
  logic          o_has_r, o_last_r;

  logic [7:0]    rdata;
  logic [15:0]   len16;
  logic [OW-1:0] len_o, need, rd_off, rd_sum, wr_sum, dr_sum, drop_n;
  logic [PW-1:0] rd_addr, wr_addr, head_adv;
  logic          full;

  // offset arithmetic: one add and one wrap compare each
  assign len16  = {hb_r[7], hb_r[6]};
  assign len_o  = OW'(len16);
  assign need   = OW'(OVERHEAD) + len_o;
  assign full   = (fill_r == FW'(BufferDepth));

  always_comb begin
    rd_off = OW'(hoff_r);
    if (cmd.rd_term) begin
      rd_off = need - OW'(1);
    end else if (cmd.rd_pay) begin
      rd_off = OW'(HDR_LEN) + OW'(idx_r);
    end
  end

  assign rd_sum  = OW'(head_r) + rd_off;
  assign rd_addr = PW'((rd_sum >= DEPTH_O) ? rd_sum - DEPTH_O : rd_sum);
  assign wr_sum  = OW'(head_r) + OW'(fill_r);
  assign wr_addr = PW'((wr_sum >= DEPTH_O) ? wr_sum - DEPTH_O : wr_sum);
  assign drop_n  = cmd.drop_frame ? need : OW'(1);
  assign dr_sum  = OW'(head_r) + drop_n;
  assign head_adv = PW'((dr_sum >= DEPTH_O) ? dr_sum - DEPTH_O : dr_sum);

  cfd_ram #(.Width(8), .Depth(BufferDepth)) u_ram (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (wr_addr),
    .wdata (rx_byte),
    .re    (cmd.rd_hdr | cmd.rd_term | cmd.rd_pay),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      fill_r <= '0;
      hoff_r <= '0;
      idx_r  <= '0;
      ov_r   <= 1'b0;
    end else begin
      if (cmd.push) begin
        if (full) begin
          head_r <= head_adv;
        end else begin
          fill_r <= fill_r + FW'(1);
        end
      end else if (cmd.drop1 || cmd.drop_frame) begin
        head_r <= head_adv;
        fill_r <= fill_r - FW'(drop_n);
      end
      if (cmd.scan_start) begin
        hoff_r <= '0;
      end else if (cmd.cap_hdr) begin
        hoff_r <= hoff_r + 3'd1;
      end
      if (cmd.pay_start) begin
        idx_r <= '0;
      end else if (cmd.load_out) begin
        idx_r <= idx_r + IW'(1);
      end
      if (cmd.load_out) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_hdr) begin
      hb_r[hoff_r] <= rdata;
    end
    if (cmd.load_out) begin
      o_maj_r  <= hb_r[4];
      o_min_r  <= hb_r[5];
      o_len_r  <= 5'(len16);
      o_idx_r  <= 4'(idx_r);
      o_has_r  <= !stat.len_zero;
      o_byte_r <= stat.len_zero ? 8'd0 : rdata;
      o_last_r <= stat.len_zero || stat.pay_last;
    end
  end

  always_comb begin
    stat.fill_ge_min = (fill_r >= FW'(MIN_JUDGE));
    stat.hdr_bad     = (hoff_r < 3'd4) && (rdata != HDR_BYTE);
    stat.hdr_last    = (hoff_r == 3'(HDR_LEN - 1));
    stat.len_ok      = (len16 <= 16'(MaxPayload));
    stat.complete    = (OW'(fill_r) >= need);
    stat.term_ok     = (rdata == END_BYTE);
    stat.len_zero    = (len16 == 16'd0);
    stat.pay_last    = (OW'(idx_r) + OW'(1) == len_o);
    stat.out_free    = !ov_r || out_ready;
  end

  assign out_valid      = ov_r;
  assign command_major  = o_maj_r;
  assign command_minor  = o_min_r;
  assign payload_length = o_len_r;
  assign byte_index     = o_idx_r;
  assign payload_byte   = o_byte_r;
  assign has_payload    = o_has_r;
  assign last           = o_last_r;
endmodule
`default_nettype wire

/* rtl/command_frame_deframer.sv */
// ----------------------------------------------------------------------------
// command_frame_deframer
// Byte-stream deframer for header/length/terminator command frames.
// ----------------------------------------------------------------------------
// Takes one received byte per request into a ring buffer and scans it for
// frames: four 0x3C header bytes, two command bytes, a little-endian 16-bit
// length (at most MaxPayload), the payload, two check bytes (not verified)
// and a 0xF3 terminator. Nothing is judged below ten buffered bytes. A bad
// header, length or terminator drops the oldest byte and the scan restarts;
// a full buffer drops its oldest byte on arrival. Each good frame yields one
// result per payload byte (last marks the final one), or a single marker
// result with has_payload low for an empty payload. The buffer sits in a
// single-read-port RAM, so each buffered byte the scan looks at is read
// through the RAM's output register before it is used. Emitting a frame
// yields one result per payload byte and stalls under output back-pressure.
// No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none
module command_frame_deframer
  import cfd_pkg::*;
#(
  parameter int unsigned MaxPayload  = MAX_PAYLOAD,
  parameter int unsigned BufferDepth = BUFFER_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  cfd_in_if.sink    in_chan,
  cfd_out_if.source out_chan
);
  cfd_cmd_t  cmd;   // sequencer commands
  cfd_stat_t stat;  // datapath status flags

  cfd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // buffer, offsets and the result register
  cfd_dp #(.MaxPayload(MaxPayload), .BufferDepth(BufferDepth)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .rx_byte        (in_chan.rx_byte),
    .cmd            (cmd),
    .stat           (stat),
    .out_ready      (out_chan.ready),
    .out_valid      (out_chan.valid),
    .command_major  (out_chan.command_major),
    .command_minor  (out_chan.command_minor),
    .payload_length (out_chan.payload_length),
    .byte_index     (out_chan.byte_index),
    .payload_byte   (out_chan.payload_byte),
    .has_payload    (out_chan.has_payload),
    .last           (out_chan.last)
  );
endmodule
`default_nettype wire

/* rtl/cfd_checker.sv */
// ----------------------------------------------------------------------------
// cfd_checker
// Port-level checks on the deframer's result channel.
// ----------------------------------------------------------------------------
`default_nettype none
module cfd_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [4:0] payload_length,
  input wire logic [3:0] byte_index,
  input wire logic [7:0] payload_byte,
  input wire logic       has_payload,
  input wire logic       last
);
  // stalled request holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(payload_byte) && $stable(byte_index))
    else $error("result dropped or changed while stalled");

  // empty marker is a lone zero result
  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !has_payload |-> last && payload_byte == 8'd0 && payload_length == 5'd0)
    else $error("bad empty-frame marker");

  // index stays inside the frame; last on the final byte
  a_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && has_payload |->
      (5'(byte_index) < payload_length || payload_length == 5'd16)
      && (last == (5'(byte_index) + 5'd1 == payload_length)))
    else $error("payload index out of step with length");

  // nothing offered straight out of reset
  a_reset: assert property (@(posedge clk) $rose(rst_n) |-> !out_valid)
    else $error("result valid after reset");
endmodule

bind command_frame_deframer cfd_checker u_cfd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .payload_length (out_chan.payload_length),
  .byte_index     (out_chan.byte_index),
  .payload_byte   (out_chan.payload_byte),
  .has_payload    (out_chan.has_payload),
  .last           (out_chan.last)
);
`default_nettype wire
